// ===== hdl/tia_pkg.sv =====
// shared constants, types and coefficient table for the triangle angle pipeline
package tia_pkg;

  localparam int unsigned EDGE_W       = 17;
  localparam int unsigned MAG_W        = 34;
  localparam int unsigned NORM_W       = 62;
  localparam int unsigned LEN_PRESHIFT = NORM_W - 2 - MAG_W;
  localparam int unsigned SHIFT_W      = 7;
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned ROOT_W       = 31;
  localparam int unsigned DEN_W        = 62;
  localparam int unsigned QUO_W        = 30;
  localparam int unsigned POLY_W       = 34;
  localparam int unsigned RAD_W        = 32;
  localparam int unsigned ANG_W        = 25;
  localparam int unsigned OUT_W        = 16;

  localparam int unsigned NORM_STEPS = 5;
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned DIV_STEPS  = 30;
  localparam int unsigned POLY_STEPS = 7;

  localparam logic [ROOT_W-1:0] ONE_Q30         = 31'h4000_0000;
  localparam logic [RAD_W-1:0]  PI_Q30          = 32'd3373259426;
  localparam logic [29:0]       DEG_PER_RAD_Q24 = 30'd961263669;

  typedef logic signed [EDGE_W-1:0] edge_t;

  typedef struct packed {
    edge_t x;
    edge_t y;
    edge_t z;
  } vec_t;

  // arccosine polynomial, q30 coefficients
  function automatic logic signed [31:0] poly_coef(input logic [2:0] idx);
    logic signed [31:0] c;
    case (idx)
      3'd0:    c = 32'sd1686629690;
      3'd1:    c = -32'sd230423709;
      3'd2:    c = 32'sd95540460;
      3'd3:    c = -32'sd53874249;
      3'd4:    c = 32'sd33169905;
      3'd5:    c = -32'sd18348235;
      3'd6:    c = 32'sd7161955;
      default: c = -32'sd1355589;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/triangle_interior_angles.sv =====
// top level: triangle corners in, interior angles in degrees out
//
//  channel  direction  handshake                 payload
//  input    in         in_valid_i / in_stall_o   corner_{a,b,c}_{x,y,z}_i
//  output   out        out_valid_o / out_stall_i angle_at_{a,b,c}_o, degenerate_o
//
// one transaction per clock when the output side keeps up
// 114 register stages: edge register, two 112-stage corner lanes, output register
// the lanes are chains of cells (31-step root chains and a 30-step divider set the depth)
// reset clears all valid bits; payload registers are not reset
// a stalled result in the output register freezes the whole pipe only when the
// last lane stage also holds a transaction; otherwise bubbles are squeezed out
module triangle_interior_angles #(
  parameter int unsigned COORD_WIDTH     = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] corner_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] corner_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner_b_z_i,
  input  logic signed [COORD_WIDTH-1:0] corner_c_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner_c_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner_c_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tia_pkg::OUT_W-1:0]    angle_at_a_o,
  output logic [tia_pkg::OUT_W-1:0]    angle_at_b_o,
  output logic [tia_pkg::OUT_W-1:0]    angle_at_c_o,
  output logic                         degenerate_o
);

  // wide coordinates drop low bits so each edge component fits 17 bits
  localparam int unsigned EdgeShift = (COORD_WIDTH > 16) ? (COORD_WIDTH - 16) : 0;
  localparam int unsigned AW        = tia_pkg::ANG_W;
  localparam logic [AW-1:0] Total   = AW'(180) << ANGLE_FRAC_BITS;

  function automatic tia_pkg::edge_t edge_of(input logic signed [COORD_WIDTH-1:0] from_c,
                                             input logic signed [COORD_WIDTH-1:0] to_c);
    logic signed [COORD_WIDTH:0] d;
    d = (COORD_WIDTH+1)'(to_c) - (COORD_WIDTH+1)'(from_c);
    return tia_pkg::edge_t'(d >>> EdgeShift);
  endfunction

  // pipeline advance: hold only when a finished result waits and another is behind it
  logic en;
  logic lane_vld;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i && lane_vld);
  assign in_stall_o = !en;

  // ---------------- edge vectors and zero-edge detect
  tia_pkg::vec_t ab_d, ac_d, ba_d, bc_d;
  logic          deg_d;

  always_comb begin
    ab_d.x = edge_of(corner_a_x_i, corner_b_x_i);
    ab_d.y = edge_of(corner_a_y_i, corner_b_y_i);
    ab_d.z = edge_of(corner_a_z_i, corner_b_z_i);
    ac_d.x = edge_of(corner_a_x_i, corner_c_x_i);
    ac_d.y = edge_of(corner_a_y_i, corner_c_y_i);
    ac_d.z = edge_of(corner_a_z_i, corner_c_z_i);
    ba_d.x = edge_of(corner_b_x_i, corner_a_x_i);
    ba_d.y = edge_of(corner_b_y_i, corner_a_y_i);
    ba_d.z = edge_of(corner_b_z_i, corner_a_z_i);
    bc_d.x = edge_of(corner_b_x_i, corner_c_x_i);
    bc_d.y = edge_of(corner_b_y_i, corner_c_y_i);
    bc_d.z = edge_of(corner_b_z_i, corner_c_z_i);
    deg_d  = (ab_d == '0) || (ac_d == '0) || (ba_d == '0) || (bc_d == '0);
  end

  logic          e_vld_q, e_deg_q;
  tia_pkg::vec_t e_ab_q, e_ac_q, e_ba_q, e_bc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_deg_q <= deg_d;
      e_ab_q  <= ab_d;
      e_ac_q  <= ac_d;
      e_ba_q  <= ba_d;
      e_bc_q  <= bc_d;
    end
  end

  // ---------------- two corner lanes in lockstep
  logic          va, vb, deg_a, deg_b;
  logic [AW-1:0] ang_a, ang_b;

  tia_corner #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_a (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(e_vld_q), .side_i(e_deg_q), .u_i(e_ab_q), .v_i(e_ac_q),
    .valid_o(va), .side_o(deg_a), .angle_o(ang_a)
  );

  tia_corner #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_b (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(e_vld_q), .side_i(e_deg_q), .u_i(e_ba_q), .v_i(e_bc_q),
    .valid_o(vb), .side_o(deg_b), .angle_o(ang_b)
  );

  assign lane_vld = va & vb;

  // ---------------- third angle, saturation, output register
  logic                      deg;
  logic [AW:0]               ang_sum;
  logic [AW-1:0]             ang_c;
  logic [tia_pkg::OUT_W-1:0] sat_a, sat_b, sat_c;

  function automatic logic [tia_pkg::OUT_W-1:0] sat16(input logic [AW-1:0] v);
    return (v > AW'({tia_pkg::OUT_W{1'b1}})) ? {tia_pkg::OUT_W{1'b1}}
                                             : v[tia_pkg::OUT_W-1:0];
  endfunction

  always_comb begin
    deg     = deg_a | deg_b;
    ang_sum = (AW+1)'(ang_a) + (AW+1)'(ang_b);
    ang_c   = (ang_sum >= (AW+1)'(Total)) ? '0 : AW'((AW+1)'(Total) - ang_sum);
    sat_a   = deg ? '0 : sat16(ang_a);
    sat_b   = deg ? '0 : sat16(ang_b);
    sat_c   = deg ? '0 : sat16(ang_c);
  end

  logic                      load_out;
  logic [tia_pkg::OUT_W-1:0] ang_a_q, ang_b_q, ang_c_q;
  logic                      deg_q;

  assign load_out = !(out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= lane_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ang_a_q <= sat_a;
      ang_b_q <= sat_b;
      ang_c_q <= sat_c;
      deg_q   <= deg;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign angle_at_a_o = ang_a_q;
  assign angle_at_b_o = ang_b_q;
  assign angle_at_c_o = ang_c_q;
  assign degenerate_o = deg_q;

  // ---------------- checks
  // a degenerate triangle reports all angles zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      angle_at_a_o == '0 && angle_at_b_o == '0 && angle_at_c_o == '0)
    else $error("degenerate result with nonzero angle");

  // input side only stalls behind a stalled, occupied output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // both lanes stay in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    va == vb && (!va || deg_a == deg_b))
    else $error("corner lanes out of step");

  // a nonzero third angle closes the sum to 180 degrees when nothing saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o && angle_at_c_o != '0 && ANGLE_FRAC_BITS <= 8 |->
      (32'(angle_at_a_o) + 32'(angle_at_b_o) + 32'(angle_at_c_o)) == 32'(Total))
    else $error("angle sum mismatch");

endmodule

// ===== hdl/tia_sqrt_cell.sv =====
// one digit step of the pipelined integer square root
module tia_sqrt_cell #(
  parameter int unsigned BIT_POS = 0,
  parameter int unsigned SIDE_W  = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [tia_pkg::WORD_W-1:0]    rem_i,
  input  logic [tia_pkg::WORD_W-1:0]    root_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [tia_pkg::WORD_W-1:0]    rem_o,
  output logic [tia_pkg::WORD_W-1:0]    root_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam logic [tia_pkg::WORD_W-1:0] Bit = 64'd1 << (2 * BIT_POS);

  logic [tia_pkg::WORD_W-1:0] trial;
  logic [tia_pkg::WORD_W-1:0] rem_d, root_d;

  always_comb begin
    trial = root_i + Bit;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + Bit;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      side_o <= side_i;
    end
  end

endmodule

// ===== hdl/tia_div_cell.sv =====
// one quotient bit of the pipelined restoring divider
module tia_div_cell #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [tia_pkg::WORD_W-1:0]  rem_i,
  input  logic [tia_pkg::DEN_W-1:0]   den_i,
  input  logic [tia_pkg::QUO_W-1:0]   quo_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [tia_pkg::WORD_W-1:0]  rem_o,
  output logic [tia_pkg::DEN_W-1:0]   den_o,
  output logic [tia_pkg::QUO_W-1:0]   quo_o,
  output logic [SIDE_W-1:0]           side_o
);

  logic [tia_pkg::WORD_W-1:0] shifted, den_ext;
  logic [tia_pkg::WORD_W-1:0] rem_d;
  logic [tia_pkg::QUO_W-1:0]  quo_d;

  always_comb begin
    shifted = {rem_i[tia_pkg::WORD_W-2:0], 1'b0};
    den_ext = tia_pkg::WORD_W'(den_i);
    if (shifted >= den_ext) begin
      rem_d = shifted - den_ext;
      quo_d = {quo_i[tia_pkg::QUO_W-2:0], 1'b1};
    end else begin
      rem_d = shifted;
      quo_d = {quo_i[tia_pkg::QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      den_o  <= den_i;
      quo_o  <= quo_d;
      side_o <= side_i;
    end
  end

endmodule

// ===== hdl/tia_corner.sv =====
// pipelined corner angle lane: dot product, lengths, ratio, arccosine, degrees
module tia_corner #(
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic                       side_i,
  input  tia_pkg::vec_t              u_i,
  input  tia_pkg::vec_t              v_i,
  output logic                       valid_o,
  output logic                       side_o,
  output logic [tia_pkg::ANG_W-1:0]  angle_o
);

  localparam int unsigned NS   = tia_pkg::NORM_STEPS;
  localparam int unsigned SQ   = tia_pkg::SQRT_STEPS;
  localparam int unsigned DS   = tia_pkg::DIV_STEPS;
  localparam int unsigned PS   = tia_pkg::POLY_STEPS;
  localparam int unsigned MW   = tia_pkg::MAG_W;
  localparam int unsigned SW   = tia_pkg::SHIFT_W;
  localparam int unsigned WW   = tia_pkg::WORD_W;
  localparam int unsigned USW  = 2 + MW + SW;
  localparam int unsigned RSW  = 2 + tia_pkg::POLY_W;

  // ---------------- products
  logic                      p_vld_q, p_side_q;
  logic signed [2*tia_pkg::EDGE_W-1:0] pd_q [3];
  logic signed [2*tia_pkg::EDGE_W-1:0] pu_q [3];
  logic signed [2*tia_pkg::EDGE_W-1:0] pv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_side_q <= side_i;
      pd_q[0]  <= u_i.x * v_i.x;
      pd_q[1]  <= u_i.y * v_i.y;
      pd_q[2]  <= u_i.z * v_i.z;
      pu_q[0]  <= u_i.x * u_i.x;
      pu_q[1]  <= u_i.y * u_i.y;
      pu_q[2]  <= u_i.z * u_i.z;
      pv_q[0]  <= v_i.x * v_i.x;
      pv_q[1]  <= v_i.y * v_i.y;
      pv_q[2]  <= v_i.z * v_i.z;
    end
  end

  // ---------------- sums
  logic signed [35:0] dot_sum, lu_sum, lv_sum;
  logic               s_vld_q, s_side_q, s_neg_q;
  logic [MW-1:0]      s_mag_q;
  logic [tia_pkg::NORM_W-1:0] s_lu_q, s_lv_q;

  always_comb begin
    dot_sum = 36'(pd_q[0]) + 36'(pd_q[1]) + 36'(pd_q[2]);
    lu_sum  = 36'(pu_q[0]) + 36'(pu_q[1]) + 36'(pu_q[2]);
    lv_sum  = 36'(pv_q[0]) + 36'(pv_q[1]) + 36'(pv_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else if (en_i) begin
      s_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_side_q <= p_side_q;
      s_neg_q  <= dot_sum[35];
      s_mag_q  <= dot_sum[35] ? MW'(-dot_sum) : MW'(dot_sum);
      s_lu_q   <= {2'b00, lu_sum[MW-1:0], {tia_pkg::LEN_PRESHIFT{1'b0}}};
      s_lv_q   <= {2'b00, lv_sum[MW-1:0], {tia_pkg::LEN_PRESHIFT{1'b0}}};
    end
  end

  // ---------------- normalize both squared lengths into [2^60, 2^62)
  logic                       nm_vld  [NS+1];
  logic                       nm_side [NS+1];
  logic                       nm_neg  [NS+1];
  logic [MW-1:0]              nm_mag  [NS+1];
  logic [tia_pkg::NORM_W-1:0] nm_u    [NS+1];
  logic [tia_pkg::NORM_W-1:0] nm_v    [NS+1];
  logic [SW-1:0]              nm_su   [NS+1];
  logic [SW-1:0]              nm_sv   [NS+1];

  assign nm_vld[0]  = s_vld_q;
  assign nm_side[0] = s_side_q;
  assign nm_neg[0]  = s_neg_q;
  assign nm_mag[0]  = s_mag_q;
  assign nm_u[0]    = s_lu_q;
  assign nm_v[0]    = s_lv_q;
  assign nm_su[0]   = SW'(tia_pkg::LEN_PRESHIFT);
  assign nm_sv[0]   = SW'(tia_pkg::LEN_PRESHIFT);

  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int unsigned K = 32 >> j;
    localparam logic [tia_pkg::NORM_W-1:0] Lim = 62'd1 << (tia_pkg::NORM_W - K);
    logic                       vld_q, side_q, neg_q;
    logic [MW-1:0]              mag_q;
    logic [tia_pkg::NORM_W-1:0] u_q, v_q;
    logic [SW-1:0]              su_q, sv_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= nm_vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q <= nm_side[j];
        neg_q  <= nm_neg[j];
        mag_q  <= nm_mag[j];
        u_q    <= (nm_u[j] < Lim) ? (nm_u[j] << K) : nm_u[j];
        su_q   <= (nm_u[j] < Lim) ? (nm_su[j] + SW'(K)) : nm_su[j];
        v_q    <= (nm_v[j] < Lim) ? (nm_v[j] << K) : nm_v[j];
        sv_q   <= (nm_v[j] < Lim) ? (nm_sv[j] + SW'(K)) : nm_sv[j];
      end
    end

    assign nm_vld[j+1]  = vld_q;
    assign nm_side[j+1] = side_q;
    assign nm_neg[j+1]  = neg_q;
    assign nm_mag[j+1]  = mag_q;
    assign nm_u[j+1]    = u_q;
    assign nm_v[j+1]    = v_q;
    assign nm_su[j+1]   = su_q;
    assign nm_sv[j+1]   = sv_q;
  end

  // ---------------- edge lengths, two root chains side by side
  logic          qu_vld  [SQ+1];
  logic [WW-1:0] qu_rem  [SQ+1];
  logic [WW-1:0] qu_root [SQ+1];
  logic [USW-1:0] qu_side [SQ+1];
  logic          qv_vld  [SQ+1];
  logic [WW-1:0] qv_rem  [SQ+1];
  logic [WW-1:0] qv_root [SQ+1];
  logic [SW-1:0] qv_side [SQ+1];

  assign qu_vld[0]  = nm_vld[NS];
  assign qu_rem[0]  = WW'(nm_u[NS]);
  assign qu_root[0] = '0;
  assign qu_side[0] = {nm_side[NS], nm_neg[NS], nm_mag[NS], nm_su[NS]};
  assign qv_vld[0]  = nm_vld[NS];
  assign qv_rem[0]  = WW'(nm_v[NS]);
  assign qv_root[0] = '0;
  assign qv_side[0] = nm_sv[NS];

  for (genvar i = 0; i < SQ; i++) begin : g_len_root
    tia_sqrt_cell #(.BIT_POS(SQ - 1 - i), .SIDE_W(USW)) u_cell_u (
      .clk_i, .rst_ni, .en_i,
      .valid_i(qu_vld[i]),   .rem_i(qu_rem[i]),   .root_i(qu_root[i]),
      .side_i(qu_side[i]),   .valid_o(qu_vld[i+1]), .rem_o(qu_rem[i+1]),
      .root_o(qu_root[i+1]), .side_o(qu_side[i+1])
    );
    tia_sqrt_cell #(.BIT_POS(SQ - 1 - i), .SIDE_W(SW)) u_cell_v (
      .clk_i, .rst_ni, .en_i,
      .valid_i(qv_vld[i]),   .rem_i(qv_rem[i]),   .root_i(qv_root[i]),
      .side_i(qv_side[i]),   .valid_o(qv_vld[i+1]), .rem_o(qv_rem[i+1]),
      .root_o(qv_root[i+1]), .side_o(qv_side[i+1])
    );
  end

  // ---------------- denominator and scaled numerator
  logic                        m_vld_q, m_side_q, m_neg_q;
  logic [tia_pkg::DEN_W-1:0]   m_den_q;
  logic [WW-1:0]               m_num_q;
  logic [SW:0]                 sh_sum;
  logic [tia_pkg::ROOT_W-1:0]  n1, n2;
  logic [MW-1:0]               u_mag;
  logic [SW-1:0]               u_su;
  logic                        u_neg, u_side;

  always_comb begin
    {u_side, u_neg, u_mag, u_su} = qu_side[SQ];
    n1     = qu_root[SQ][tia_pkg::ROOT_W-1:0];
    n2     = qv_root[SQ][tia_pkg::ROOT_W-1:0];
    sh_sum = (SW+1)'(u_su) + (SW+1)'(qv_side[SQ]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en_i) begin
      m_vld_q <= qu_vld[SQ] & qv_vld[SQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_side_q <= u_side;
      m_neg_q  <= u_neg;
      m_den_q  <= tia_pkg::DEN_W'(n1) * tia_pkg::DEN_W'(n2);
      m_num_q  <= WW'(u_mag) << sh_sum[SW:1];
    end
  end

  // ---------------- clamp test
  logic                      c_vld_q, c_side_q, c_neg_q, c_one_q;
  logic [tia_pkg::DEN_W-1:0] c_den_q;
  logic [WW-1:0]             c_rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      c_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_side_q <= m_side_q;
      c_neg_q  <= m_neg_q;
      c_one_q  <= m_num_q >= WW'(m_den_q);
      c_den_q  <= m_den_q;
      c_rem_q  <= m_num_q;
    end
  end

  // ---------------- ratio, one quotient bit per cell
  logic                       dv_vld  [DS+1];
  logic [WW-1:0]              dv_rem  [DS+1];
  logic [tia_pkg::DEN_W-1:0]  dv_den  [DS+1];
  logic [tia_pkg::QUO_W-1:0]  dv_quo  [DS+1];
  logic [2:0]                 dv_side [DS+1];

  assign dv_vld[0]  = c_vld_q;
  assign dv_rem[0]  = c_rem_q;
  assign dv_den[0]  = c_den_q;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = {c_side_q, c_neg_q, c_one_q};

  for (genvar i = 0; i < DS; i++) begin : g_div
    tia_div_cell #(.SIDE_W(3)) u_cell (
      .clk_i, .rst_ni, .en_i,
      .valid_i(dv_vld[i]),  .rem_i(dv_rem[i]),   .den_i(dv_den[i]),
      .quo_i(dv_quo[i]),    .side_i(dv_side[i]), .valid_o(dv_vld[i+1]),
      .rem_o(dv_rem[i+1]),  .den_o(dv_den[i+1]), .quo_o(dv_quo[i+1]),
      .side_o(dv_side[i+1])
    );
  end

  // ---------------- horner polynomial, one coefficient per stage
  logic                              py_vld  [PS+1];
  logic                              py_side [PS+1];
  logic                              py_neg  [PS+1];
  logic [tia_pkg::ROOT_W-1:0]        py_q    [PS+1];
  logic signed [tia_pkg::POLY_W-1:0] py_p    [PS+1];

  assign py_vld[0]  = dv_vld[DS];
  assign py_side[0] = dv_side[DS][2];
  assign py_neg[0]  = dv_side[DS][1];
  assign py_q[0]    = dv_side[DS][0] ? tia_pkg::ONE_Q30
                                     : tia_pkg::ROOT_W'(dv_quo[DS]);
  assign py_p[0]    = tia_pkg::POLY_W'(tia_pkg::poly_coef(3'd7));

  for (genvar i = 0; i < PS; i++) begin : g_poly
    localparam logic [2:0] CoefIdx = 3'(PS - 1 - i);
    logic                              vld_q, side_q, neg_q;
    logic [tia_pkg::ROOT_W-1:0]        q_q;
    logic signed [tia_pkg::POLY_W-1:0] p_q, p_d;
    logic                              p_neg;
    logic [tia_pkg::POLY_W-1:0]        p_mag;
    logic [64:0]                       prod;
    logic signed [35:0]                term;

    always_comb begin
      p_neg = py_p[i][tia_pkg::POLY_W-1];
      p_mag = p_neg ? tia_pkg::POLY_W'(-py_p[i]) : tia_pkg::POLY_W'(py_p[i]);
      prod  = 65'(p_mag) * 65'(py_q[i]);
      term  = $signed({1'b0, prod[64:30]});
      if (p_neg) begin
        term = -term;
      end
      p_d = tia_pkg::POLY_W'(term + 36'(tia_pkg::poly_coef(CoefIdx)));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= py_vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q <= py_side[i];
        neg_q  <= py_neg[i];
        q_q    <= py_q[i];
        p_q    <= p_d;
      end
    end

    assign py_vld[i+1]  = vld_q;
    assign py_side[i+1] = side_q;
    assign py_neg[i+1]  = neg_q;
    assign py_q[i+1]    = q_q;
    assign py_p[i+1]    = p_q;
  end

  // ---------------- sqrt(1 - r)
  logic                       rt_vld  [SQ+1];
  logic [WW-1:0]              rt_rem  [SQ+1];
  logic [WW-1:0]              rt_root [SQ+1];
  logic [RSW-1:0]             rt_side [SQ+1];
  logic [tia_pkg::ROOT_W-1:0] one_minus_q;

  assign one_minus_q = tia_pkg::ONE_Q30 - py_q[PS];
  assign rt_vld[0]   = py_vld[PS];
  assign rt_rem[0]   = {3'b000, one_minus_q, 30'd0};
  assign rt_root[0]  = '0;
  assign rt_side[0]  = {py_side[PS], py_neg[PS], py_p[PS]};

  for (genvar i = 0; i < SQ; i++) begin : g_acos_root
    tia_sqrt_cell #(.BIT_POS(SQ - 1 - i), .SIDE_W(RSW)) u_cell (
      .clk_i, .rst_ni, .en_i,
      .valid_i(rt_vld[i]),   .rem_i(rt_rem[i]),     .root_i(rt_root[i]),
      .side_i(rt_side[i]),   .valid_o(rt_vld[i+1]), .rem_o(rt_rem[i+1]),
      .root_o(rt_root[i+1]), .side_o(rt_side[i+1])
    );
  end

  // ---------------- radians
  logic                              r_vld_q, r_side_q, r_neg_q;
  logic [tia_pkg::RAD_W-1:0]         r_rad_q;
  logic signed [tia_pkg::POLY_W-1:0] f_p;
  logic                              f_neg, f_side;
  logic [tia_pkg::POLY_W-2:0]        p_pos;
  logic [WW-1:0]                     rad_prod;

  always_comb begin
    {f_side, f_neg, f_p} = rt_side[SQ];
    p_pos    = f_p[tia_pkg::POLY_W-1] ? '0 : f_p[tia_pkg::POLY_W-2:0];
    rad_prod = WW'(p_pos) * WW'(rt_root[SQ][tia_pkg::ROOT_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (en_i) begin
      r_vld_q <= rt_vld[SQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_side_q <= f_side;
      r_neg_q  <= f_neg;
      r_rad_q  <= rad_prod[30 +: tia_pkg::RAD_W];
    end
  end

  // ---------------- obtuse side: pi minus angle
  logic                      a_vld_q, a_side_q;
  logic [tia_pkg::RAD_W-1:0] a_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_side_q <= r_side_q;
      if (!r_neg_q) begin
        a_rad_q <= r_rad_q;
      end else if (r_rad_q > tia_pkg::PI_Q30) begin
        a_rad_q <= '0;
      end else begin
        a_rad_q <= tia_pkg::PI_Q30 - r_rad_q;
      end
    end
  end

  // ---------------- degrees
  logic        g_vld_q, g_side_q;
  logic [61:0] g_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en_i) begin
      g_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_side_q <= a_side_q;
      g_prod_q <= 62'(a_rad_q) * 62'(tia_pkg::DEG_PER_RAD_Q24);
    end
  end

  // round half up to the angle fraction
  localparam int unsigned RndPos = 53 - ANGLE_FRAC_BITS;
  logic [62:0] rnd_sum;
  logic [62:0] rnd_shift;

  always_comb begin
    rnd_sum   = 63'(g_prod_q) + (63'd1 << RndPos);
    rnd_shift = rnd_sum >> (RndPos + 1);
  end

  logic                      h_vld_q, h_side_q;
  logic [tia_pkg::ANG_W-1:0] h_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else if (en_i) begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_side_q <= g_side_q;
      h_ang_q  <= rnd_shift[tia_pkg::ANG_W-1:0];
    end
  end

  assign valid_o = h_vld_q;
  assign side_o  = h_side_q;
  assign angle_o = h_ang_q;

endmodule
